@@ sv/dtafd_pkg.sv @@
// Shared types, constants and helpers for the delta-table audio frame decoder.
// No dependencies.
package dtafd_pkg;

  localparam int MaxChannels = 4;
  localparam int TableDepth  = 256;
  localparam int MaxFrameLen = 4096;

  typedef enum logic [2:0] {
    OP_ZERO_RUN,
    OP_ERROR,
    OP_NEW_FRAME,
    OP_START,
    OP_TABLE,
    OP_CODES
  } op_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_ZERO   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  localparam logic [1:0] CFG_FRAME_LENGTH = 2'd0;
  localparam logic [1:0] CFG_CHANNELS     = 2'd1;

  typedef struct packed {
    op_t         op;
    logic [15:0] word;
    logic [8:0]  aux;
    logic [3:0]  bits;
  } cmd_t;

  function automatic logic [4:0] code_width(input logic [3:0] bits);
    code_width = (bits == 4'd0) ? 5'd16 : {1'b0, bits};
  endfunction

  function automatic logic [4:0] codes_per_word(input logic [3:0] bits);
    case (bits)
      4'd1:    codes_per_word = 5'd16;
      4'd2:    codes_per_word = 5'd8;
      4'd3:    codes_per_word = 5'd5;
      4'd4:    codes_per_word = 5'd4;
      4'd5:    codes_per_word = 5'd3;
      4'd6, 4'd7, 4'd8: codes_per_word = 5'd2;
      default: codes_per_word = 5'd1;
    endcase
  endfunction

  function automatic logic [15:0] code_mask(input logic [3:0] bits);
    code_mask = (bits == 4'd0) ? 16'hFFFF : 16'((17'd1 << bits) - 17'd1);
  endfunction

endpackage

@@ sv/dtafd_if.sv @@
// Handshake channel interfaces: stream words in, results out, register writes.
// Depends on nothing.
interface dtafd_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] stream_word;
  modport source (output valid, output stream_word, input ready);
  modport sink   (input valid, input stream_word, output ready);
endinterface

interface dtafd_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] sample;
  logic [1:0]         channel;
  logic [21:0]        zero_count;
  logic               last;
  modport source (output valid, output kind, output sample, output channel,
                  output zero_count, output last, input ready);
  modport sink   (input valid, input kind, input sample, input channel,
                  input zero_count, input last, output ready);
endinterface

interface dtafd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/dtafd_front.sv @@
// Front end: parses stream words into commands, tracking frame phase and code count.
// Depends on dtafd_pkg.
module dtafd_front #(
  parameter int MAX_CHANNELS  = dtafd_pkg::MaxChannels,
  parameter int MAX_FRAME_LEN = dtafd_pkg::MaxFrameLen
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic [15:0]     word,
  input  logic [16:0]     eff_len,
  input  logic [3:0]      nch,
  output dtafd_pkg::cmd_t cmd
);
  import dtafd_pkg::*;

  localparam int CLW = $clog2(MAX_FRAME_LEN * MAX_CHANNELS + 1);

  typedef enum logic [1:0] {PH_HEADER, PH_START, PH_TABLE, PH_CODES} phase_t;

  phase_t         phase;
  logic [3:0]     code_bits;
  logic [8:0]     table_count;
  logic [8:0]     load_index;
  logic [CLW-1:0] codes_left;
  logic [4:0]     per;
  logic [4:0]     take;

  assign per  = codes_per_word(code_bits);
  assign take = (codes_left < CLW'(per)) ? 5'(codes_left) : per;

  always_comb begin
    cmd.word = word;
    cmd.bits = code_bits;
    cmd.aux  = load_index;
    case (phase)
      PH_HEADER: begin
        cmd.aux = {1'b0, word[7:0]};
        if (word[15]) begin
          cmd.op = OP_ZERO_RUN;
        end else if (word[14:12] != 3'd0) begin
          cmd.op = OP_ERROR;
        end else begin
          cmd.op = OP_NEW_FRAME;
        end
      end
      PH_START: cmd.op = OP_START;
      PH_TABLE: cmd.op = OP_TABLE;
      default: begin
        cmd.op  = OP_CODES;
        cmd.aux = {4'd0, take};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      code_bits   <= '0;
      table_count <= '0;
      load_index  <= '0;
      codes_left  <= '0;
    end else if (push) begin
      case (phase)
        PH_HEADER: begin
          if (!word[15] && word[14:12] == 3'd0) begin
            code_bits   <= word[3:0];
            table_count <= {1'b0, word[11:4]} + 9'd1;
            load_index  <= '0;
            codes_left  <= CLW'((eff_len - 17'd1) * nch);
            phase       <= PH_START;
          end
        end
        PH_START: begin
          if ({5'd0, load_index} + 14'd1 >= {10'd0, nch}) begin
            load_index <= '0;
            phase      <= PH_TABLE;
          end else begin
            load_index <= load_index + 9'd1;
          end
        end
        PH_TABLE: begin
          if (load_index + 9'd1 >= table_count) begin
            load_index <= '0;
            phase      <= (codes_left != '0) ? PH_CODES : PH_HEADER;
          end else begin
            load_index <= load_index + 9'd1;
          end
        end
        default: begin
          codes_left <= codes_left - CLW'(take);
          if (codes_left == CLW'(take)) phase <= PH_HEADER;
        end
      endcase
    end
  end

endmodule

@@ sv/dtafd_queue.sv @@
// Two-entry command queue between front and back end.
// Depends on dtafd_pkg.
module dtafd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dtafd_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            avail,
  output dtafd_pkg::cmd_t head
);
  import dtafd_pkg::*;

  cmd_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ sv/dtafd_back.sv @@
// Back end: executes commands, holds table memory and predictors, drives results.
// Depends on dtafd_pkg.
module dtafd_back #(
  parameter int MAX_CHANNELS = dtafd_pkg::MaxChannels,
  parameter int TABLE_DEPTH  = dtafd_pkg::TableDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               avail,
  input  dtafd_pkg::cmd_t    head,
  output logic               pop,
  input  logic [16:0]        eff_len,
  input  logic [3:0]         nch,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [1:0]         kind,
  output logic signed [15:0] sample,
  output logic [1:0]         channel,
  output logic [21:0]        zero_count,
  output logic               last
);
  import dtafd_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL1, ST_MUL2, ST_CODE} state_t;

  logic [15:0] qtab [TABLE_DEPTH];
  logic [15:0] pred [MAX_CHANNELS];

  state_t      state;
  logic        free;
  logic [7:0]  run_frames;
  logic [20:0] run_prod;
  logic [15:0] cw;
  logic [4:0]  cnt;
  logic [3:0]  bits;
  logic [CW-1:0] ch;
  logic [15:0] raddr;
  logic [15:0] rdata;
  logic        rin;
  logic [15:0] cw_next;
  logic [15:0] sum;
  logic [28:0] run_full;

  assign free     = !res_valid || res_ready;
  assign pop      = (state == ST_IDLE) && avail && free;
  assign cw_next  = cw >> code_width(bits);
  assign sum      = pred[ch] + (rin ? rdata : 16'd0);
  assign run_full = run_prod * run_frames;

  always_comb begin
    if (state == ST_IDLE) begin
      raddr = head.word & code_mask(head.bits);
    end else if (free) begin
      raddr = cw_next & code_mask(bits);
    end else begin
      raddr = cw & code_mask(bits);
    end
  end

  always_ff @(posedge clk) begin
    rdata <= qtab[AW'(raddr)];
    rin   <= ({16'd0, raddr} < 32'(TABLE_DEPTH));
    if (pop && head.op == OP_TABLE && {23'd0, head.aux} < 32'(TABLE_DEPTH)) begin
      qtab[AW'(head.aux)] <= head.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      ch        <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) pred[i] <= '0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (pop) begin
            kind       <= KIND_SAMPLE;
            sample     <= '0;
            channel    <= '0;
            zero_count <= '0;
            last       <= 1'b1;
            case (head.op)
              OP_ZERO_RUN: begin
                run_frames <= head.aux[7:0];
                state      <= ST_MUL1;
              end
              OP_ERROR: begin
                kind      <= KIND_ERROR;
                res_valid <= 1'b1;
              end
              OP_NEW_FRAME: ch <= '0;
              OP_START: begin
                pred[CW'(head.aux)] <= head.word;
                sample    <= head.word;
                channel   <= 2'(head.aux);
                res_valid <= 1'b1;
              end
              OP_CODES: begin
                cw    <= head.word;
                cnt   <= head.aux[4:0];
                bits  <= head.bits;
                state <= ST_CODE;
              end
              default: ;
            endcase
          end
        end
        ST_MUL1: begin
          run_prod <= 21'(eff_len * nch);
          state    <= ST_MUL2;
        end
        ST_MUL2: begin
          if (free) begin
            kind       <= KIND_ZERO;
            zero_count <= run_full[21:0];
            res_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          if (free) begin
            pred[ch]  <= sum;
            kind      <= KIND_SAMPLE;
            sample    <= sum;
            channel   <= 2'(ch);
            last      <= (cnt == 5'd1);
            res_valid <= 1'b1;
            cw        <= cw_next;
            cnt       <= cnt - 5'd1;
            ch        <= ({1'b0, ch} + 5'd1 >= {1'b0, nch}) ? '0 : ch + CW'(1);
            if (cnt == 5'd1) state <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

@@ sv/delta_table_audio_frame_decoder.sv @@
// Top level: config registers, front parser, command queue and back end.
// Depends on dtafd_pkg, dtafd_if, dtafd_front, dtafd_queue, dtafd_back.
// Throughput: one result per cycle from the back end while it decodes a packed word
// and result.ready is high; a packed word holds up to 16 codes, the first looked up on pop.
// Reset: rst synchronous; clears phase, predictors, queue; table memory is not cleared.
module delta_table_audio_frame_decoder #(
  parameter int MAX_CHANNELS  = dtafd_pkg::MaxChannels,
  parameter int TABLE_DEPTH   = dtafd_pkg::TableDepth,
  parameter int MAX_FRAME_LEN = dtafd_pkg::MaxFrameLen
) (
  input logic           clk,
  input logic           rst,
  dtafd_word_if.sink    stream,
  dtafd_result_if.source result,
  dtafd_cfg_if.sink     cfg
);
  import dtafd_pkg::*;

  logic [12:0] frame_length;
  logic [2:0]  channels;
  logic [16:0] eff_len;
  logic [3:0]  nch;
  logic        full;
  logic        avail;
  logic        pop;
  logic        push;
  cmd_t        front_cmd;
  cmd_t        head;

  assign cfg.ready    = 1'b1;
  assign stream.ready = !full;
  assign push         = stream.valid && !full;

  assign eff_len = (frame_length == '0) ? 17'd1 :
                   ({4'd0, frame_length} > 17'(MAX_FRAME_LEN)) ? 17'(MAX_FRAME_LEN) :
                   {4'd0, frame_length};
  assign nch = (channels == '0) ? 4'd1 :
               ({1'b0, channels} > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) :
               {1'b0, channels};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= 13'd256;
      channels     <= 3'd2;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_FRAME_LENGTH: frame_length <= cfg.data;
        CFG_CHANNELS:     channels     <= cfg.data[2:0];
        default: ;
      endcase
    end
  end

  dtafd_front #(.MAX_CHANNELS(MAX_CHANNELS), .MAX_FRAME_LEN(MAX_FRAME_LEN)) u_front (
    .clk(clk), .rst(rst), .push(push), .word(stream.stream_word),
    .eff_len(eff_len), .nch(nch), .cmd(front_cmd)
  );

  dtafd_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_cmd(front_cmd), .full(full),
    .pop(pop), .avail(avail), .head(head)
  );

  dtafd_back #(.MAX_CHANNELS(MAX_CHANNELS), .TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst(rst), .avail(avail), .head(head), .pop(pop),
    .eff_len(eff_len), .nch(nch),
    .res_valid(result.valid), .res_ready(result.ready), .kind(result.kind),
    .sample(result.sample), .channel(result.channel),
    .zero_count(result.zero_count), .last(result.last)
  );

endmodule

@@ sv/dtafd_checker.sv @@
// Port-level checks for the decoder and the bind that attaches them.
// Depends on delta_table_audio_frame_decoder.
module dtafd_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] kind,
  input logic       last,
  input logic [21:0] zero_count
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> kind != 2'd3)
    else $error("invalid result kind");

  a_single: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind != 2'd0 |-> last)
    else $error("run or error result not marked last");

  a_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  a_zc: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == 2'd2 |-> zero_count == 22'd0)
    else $error("error result carries a count");

endmodule

bind delta_table_audio_frame_decoder dtafd_checker u_dtafd_checker (
  .clk(clk), .rst(rst), .res_valid(result.valid), .res_ready(result.ready),
  .kind(result.kind), .last(result.last), .zero_count(result.zero_count)
);

@@ dv/tb_delta_table_audio_frame_decoder.sv @@
// Self-checking bench for the delta-table audio frame decoder: a directed
// stimulus table, then random frames, all checked against an in-bench decoder.
// Depends on dtafd_pkg, the dtafd_*_if interfaces and the decoder RTL.
module tb_delta_table_audio_frame_decoder;
  import dtafd_pkg::*;

  typedef enum logic [1:0] {PH_HEADER, PH_START, PH_TABLE, PH_CODES} dec_phase_t;

  typedef struct {
    kind_t       kind;
    logic [15:0] sample;
    logic [1:0]  channel;
    logic [21:0] zero_count;
    logic        last;
  } pcm_rec_t;

  typedef struct {
    bit          chk;
    kind_t       kind;
    logic [15:0] sample;
    logic [21:0] zero_count;
  } pinned_t;

  typedef struct {
    bit          is_cfg;
    logic [12:0] len;
    logic [12:0] chn;
    logic [15:0] w;
    pinned_t     pin;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dtafd_word_if   wrd ();
  dtafd_result_if res ();
  dtafd_cfg_if    cfg_bus ();

  delta_table_audio_frame_decoder u_dut (
    .clk   (clk),
    .rst   (rst),
    .stream(wrd),
    .result(res),
    .cfg   (cfg_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // decoder mirror
  logic [12:0] cfg_len = 13'd256;
  logic [2:0]  cfg_chn = 3'd2;
  dec_phase_t  ph = PH_HEADER;
  logic [15:0] pred [MaxChannels];
  logic [15:0] qtab [TableDepth];
  int          tcount, lidx, cbits, cleft, cur_ch;

  pcm_rec_t pcm_q [$];
  pcm_rec_t word_out [$];
  pinned_t  pinned_q [$];

  int errors = 0;
  int src_idle = 0;
  int snk_idle = 0;
  int cycles = 0;
  localparam int CycleLimit = 2_000_000;

  function automatic int eff_len();
    if (cfg_len == 0) return 1;
    if (cfg_len > MaxFrameLen) return MaxFrameLen;
    return cfg_len;
  endfunction

  function automatic int eff_ch();
    if (cfg_chn == 0) return 1;
    if (cfg_chn > MaxChannels) return MaxChannels;
    return cfg_chn;
  endfunction

  function automatic void emit_pcm(kind_t k, logic [15:0] s, int c, logic [21:0] zc);
    pcm_rec_t r;
    r.kind = k;
    r.sample = s;
    r.channel = c[1:0];
    r.zero_count = zc;
    r.last = 1'b0;
    word_out.push_back(r);
  endfunction

  function automatic void decode_word(logic [15:0] w);
    int nch, bits, per;
    logic [15:0] mask, packed_w, add;
    int idx;
    nch = eff_ch();
    word_out.delete();
    case (ph)
      PH_HEADER: begin
        if (w[15]) begin
          emit_pcm(KIND_ZERO, 16'd0, 0, 22'(eff_len() * nch * int'(w[7:0])));
        end else if (w[14:12] != 3'd0) begin
          emit_pcm(KIND_ERROR, 16'd0, 0, 22'd0);
        end else begin
          cbits = w[3:0];
          tcount = int'(w[11:4]) + 1;
          lidx = 0;
          cur_ch = 0;
          cleft = (eff_len() - 1) * nch;
          ph = PH_START;
        end
      end
      PH_START: begin
        pred[lidx] = w;
        emit_pcm(KIND_SAMPLE, w, lidx, 22'd0);
        lidx++;
        if (lidx >= nch) begin
          lidx = 0;
          ph = PH_TABLE;
        end
      end
      PH_TABLE: begin
        if (lidx < TableDepth) qtab[lidx] = w;
        lidx++;
        if (lidx >= tcount) begin
          lidx = 0;
          cur_ch = 0;
          ph = (cleft != 0) ? PH_CODES : PH_HEADER;
        end
      end
      default: begin
        bits = (cbits == 0) ? 16 : cbits;
        per = 16 / bits;
        mask = (bits == 16) ? 16'hFFFF : 16'((1 << bits) - 1);
        packed_w = w;
        for (int i = 0; i < per && cleft != 0; i++) begin
          idx = packed_w & mask;
          add = (idx < TableDepth) ? qtab[idx] : 16'd0;
          pred[cur_ch] = pred[cur_ch] + add;
          emit_pcm(KIND_SAMPLE, pred[cur_ch], cur_ch, 22'd0);
          packed_w = 16'(32'(packed_w) >> bits);
          cleft--;
          cur_ch = (cur_ch + 1 >= nch) ? 0 : cur_ch + 1;
        end
        if (cleft == 0) begin
          ph = PH_HEADER;
          cur_ch = 0;
        end
      end
    endcase
    if (word_out.size() > 0) word_out[word_out.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    pcm_rec_t e;
    pinned_t p;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end else if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        if (cfg_bus.index == CFG_FRAME_LENGTH) cfg_len = cfg_bus.data;
        else if (cfg_bus.index == CFG_CHANNELS) cfg_chn = cfg_bus.data[2:0];
      end
      if (wrd.valid && wrd.ready) begin
        decode_word(wrd.stream_word);
        if (pinned_q.size() > 0) begin
          p = pinned_q.pop_front();
          if (p.chk && (word_out.size() == 0 || word_out[0].kind != p.kind ||
              word_out[0].sample != p.sample || word_out[0].zero_count != p.zero_count)) begin
            errors++;
            $display("%0t pinned value off for word %h: expected kind %0d sample %h zc %0d",
                     $time, wrd.stream_word, p.kind, p.sample, p.zero_count);
          end
        end
        foreach (word_out[i]) pcm_q.push_back(word_out[i]);
      end
      if (res.valid && res.ready) begin
        if (pcm_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result: kind %0d sample %h channel %0d zc %0d last %0b",
                   $time, res.kind, res.sample, res.channel, res.zero_count, res.last);
        end else begin
          e = pcm_q.pop_front();
          if (res.kind != e.kind || res.sample != e.sample || res.channel != e.channel ||
              res.zero_count != e.zero_count || res.last != e.last) begin
            errors++;
            $display("%0t mismatch: expected kind %0d sample %h channel %0d zc %0d last %0b",
                     $time, e.kind, e.sample, e.channel, e.zero_count, e.last);
            $display("%0t            actual kind %0d sample %h channel %0d zc %0d last %0b",
                     $time, res.kind, res.sample, res.channel, res.zero_count, res.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    res.ready <= ($urandom_range(99) >= snk_idle);
  end

  task automatic send_word(input logic [15:0] w, input pinned_t p);
    pinned_q.push_back(p);
    if ($urandom_range(99) < src_idle) begin
      wrd.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle);
    end
    wrd.valid <= 1'b1;
    wrd.stream_word <= w;
    do @(posedge clk); while (!wrd.ready);
  endtask

  task automatic drain();
    wrd.valid <= 1'b0;
    do @(posedge clk); while (pcm_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [12:0] len, input logic [12:0] chn);
    drain();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= CFG_FRAME_LENGTH;
    cfg_bus.data  <= len;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.index <= CFG_CHANNELS;
    cfg_bus.data  <= chn;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_code(int bits, int tc);
    logic [15:0] mask;
    int hi;
    mask = (bits == 16) ? 16'hFFFF : 16'((1 << bits) - 1);
    if (bits > 8 && $urandom_range(3) == 0) return 16'($urandom_range(int'(mask), TableDepth));
    hi = (tc - 1 < int'(mask)) ? tc - 1 : int'(mask);
    return 16'($urandom_range(hi));
  endfunction

  task automatic send_frame(input bit coded_ok, inout int sent);
    pinned_t none;
    logic [15:0] w;
    int sel, tc, bits, per, nc, pos;
    none = '{chk: 1'b0, kind: KIND_SAMPLE, sample: '0, zero_count: '0};
    sel = $urandom_range(99);
    if (!coded_ok || sel < 30) begin
      if (sel % 2 == 0) w = {1'b1, 15'($urandom)};
      else w = {1'b0, 3'($urandom_range(7, 1)), 12'($urandom)};
      send_word(w, none);
      sent++;
    end else begin
      tc = ($urandom_range(29) == 0) ? $urandom_range(256, 1) : $urandom_range(16, 1);
      w = {4'd0, 8'(tc - 1), 4'($urandom)};
      bits = (w[3:0] == 0) ? 16 : w[3:0];
      per = 16 / bits;
      send_word(w, none);
      for (int c = 0; c < eff_ch(); c++) send_word(16'($urandom), none);
      for (int t = 0; t < tc; t++) send_word(16'($urandom), none);
      nc = (eff_len() - 1) * eff_ch();
      while (nc > 0) begin
        w = 16'($urandom);
        pos = 0;
        for (int i = 0; i < per && nc > 0; i++) begin
          w = (w & ~(16'((1 << bits) - 1) << pos)) | (pick_code(bits, tc) << pos);
          pos += bits;
          nc--;
        end
        send_word(w, none);
        sent++;
      end
      sent += 1 + eff_ch() + tc;
    end
  endtask

  row_t dir_rows [$];

  function automatic void add_row(logic [15:0] w, bit chk, kind_t k, logic [15:0] s,
                                  logic [21:0] zc);
    dir_rows.push_back('{is_cfg: 1'b0, len: '0, chn: '0, w: w,
                         pin: '{chk: chk, kind: k, sample: s, zero_count: zc}});
  endfunction

  function automatic void add_cfg(logic [12:0] len, logic [12:0] chn);
    dir_rows.push_back('{is_cfg: 1'b1, len: len, chn: chn, w: '0,
                         pin: '{chk: 1'b0, kind: KIND_SAMPLE, sample: '0, zero_count: '0}});
  endfunction

  initial begin
    int sent;
    logic [12:0] set_len [6] = '{13'd3, 13'd0, 13'd6, 13'd4096, 13'd8191, 13'd2};
    logic [12:0] set_chn [6] = '{13'd2, 13'd0, 13'd4, 13'd4, 13'd7, 13'd3};
    bit          set_cod [6] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

    wrd.valid = 1'b0;
    wrd.stream_word = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_FRAME_LENGTH;
    cfg_bus.data = '0;
    res.ready = 1'b0;
    foreach (pred[i]) pred[i] = '0;
    foreach (qtab[i]) qtab[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(16'h8001, 1, KIND_ZERO,   16'h0000, 22'd512);
    add_row(16'h8000, 1, KIND_ZERO,   16'h0000, 22'd0);
    add_row(16'h80FF, 1, KIND_ZERO,   16'h0000, 22'd130560);
    add_row(16'h7000, 1, KIND_ERROR,  16'h0000, 22'd0);
    add_row(16'h1FFF, 1, KIND_ERROR,  16'h0000, 22'd0);
    add_cfg(13'd3, 13'd2);
    add_row(16'h0011, 0, KIND_SAMPLE, 16'h0000, 22'd0);
    add_row(16'h7FFF, 1, KIND_SAMPLE, 16'h7FFF, 22'd0);
    add_row(16'h8000, 1, KIND_SAMPLE, 16'h8000, 22'd0);
    add_row(16'h0001, 0, KIND_SAMPLE, 16'h0000, 22'd0);
    add_row(16'hFFFF, 0, KIND_SAMPLE, 16'h0000, 22'd0);
    add_row(16'hAAA5, 1, KIND_SAMPLE, 16'h7FFE, 22'd0);
    add_cfg(13'd2, 13'd1);
    add_row(16'h0000, 0, KIND_SAMPLE, 16'h0000, 22'd0);
    add_row(16'h1234, 1, KIND_SAMPLE, 16'h1234, 22'd0);
    add_row(16'h0100, 0, KIND_SAMPLE, 16'h0000, 22'd0);
    add_row(16'hFFFF, 1, KIND_SAMPLE, 16'h1234, 22'd0);
    add_row(16'h0000, 0, KIND_SAMPLE, 16'h0000, 22'd0);
    add_row(16'h0000, 1, KIND_SAMPLE, 16'h0000, 22'd0);
    add_row(16'h0100, 0, KIND_SAMPLE, 16'h0000, 22'd0);
    add_row(16'h0000, 1, KIND_SAMPLE, 16'h0100, 22'd0);
    add_cfg(13'd1, 13'd1);
    add_row(16'h0018, 0, KIND_SAMPLE, 16'h0000, 22'd0);
    add_row(16'h5555, 1, KIND_SAMPLE, 16'h5555, 22'd0);
    add_row(16'h1111, 0, KIND_SAMPLE, 16'h0000, 22'd0);
    add_row(16'h2222, 0, KIND_SAMPLE, 16'h0000, 22'd0);
    add_row(16'h8003, 1, KIND_ZERO,   16'h0000, 22'd3);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_cfg(dir_rows[i].len, dir_rows[i].chn);
      else send_word(dir_rows[i].w, dir_rows[i].pin);
    end

    for (int s = 0; s < 6; s++) begin
      write_cfg(set_len[s], set_chn[s]);
      src_idle = (s < 2) ? 28 : (s < 4) ? 59 : 0;
      snk_idle = (s < 2) ? 59 : (s < 4) ? 28 : 0;
      sent = 0;
      while (sent < 20) send_frame(set_cod[s], sent);
      // wait for the mirror to reach header phase, then send a silence header before the next setting
      while (ph != PH_HEADER) begin
        @(posedge clk);
      end
      send_word(16'h8001, '{chk: 1'b0, kind: KIND_SAMPLE, sample: '0, zero_count: '0});
    end

    drain();
    if (errors == 0 && pcm_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/dtafd_pkg.sv
sv/dtafd_if.sv
sv/dtafd_front.sv
sv/dtafd_queue.sv
sv/dtafd_back.sv
sv/delta_table_audio_frame_decoder.sv
sv/dtafd_checker.sv
dv/tb_delta_table_audio_frame_decoder.sv
